// ----- hw/rtl/lwbc_pkg.sv -----
// Package for the LRU write-back block cache directory.
// It holds the request and command codes and the control/status structs that pass between
// the controller and the datapath. It depends on nothing.
package lwbc_pkg;

	localparam int MODE_W         = 2;
	localparam int BLOCK_NUMBER_W = 24;
	localparam int ACTION_W       = 3;
	localparam int SLOT_W         = 4;
	localparam int IN_TDATA_W     = 32;
	localparam int OUT_TDATA_W    = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_READ     = 2'd0,
		MODE_WRITE    = 2'd1,
		MODE_SYNC_ALL = 2'd2,
		MODE_SYNC_ONE = 2'd3
	} mode_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SERVE = 3'd0,
		ACT_FILL  = 3'd1,
		ACT_WBACK = 3'd2,
		ACT_TAKE  = 3'd3,
		ACT_NONE  = 3'd4
	} action_t;

	// which result the datapath loads into the output register
	typedef enum logic [1:0] {
		EM_VICTIM = 2'd0,
		EM_FILL   = 2'd1,
		EM_FINAL  = 2'd2,
		EM_SYNC   = 2'd3
	} emit_sel_t;

	typedef struct packed {
		logic      accept;
		logic      lookup;
		logic      decide;
		logic      emit;
		emit_sel_t emit_sel;
	} lwbc_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  hit;
		logic  evict_dirty;
		logic  sync_last;
		logic  out_free;
	} lwbc_status_t;

endpackage

// ----- hw/rtl/lwbc_ctrl.sv -----
// Controller state machine of the block cache directory.
// Sequences lookup, decision and the result list of one request; uses lwbc_pkg.
module lwbc_ctrl import lwbc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  lwbc_status_t status,
	output lwbc_cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_LOOKUP = 7'b0000010,
		ST_DECIDE = 7'b0000100,
		ST_WBACK  = 7'b0001000,
		ST_FILL   = 7'b0010000,
		ST_FINAL  = 7'b0100000,
		ST_SYNC   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   rd_or_wr;

	assign rd_or_wr = (status.mode == MODE_READ) || (status.mode == MODE_WRITE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.emit_sel = EM_FINAL;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = (status.mode == MODE_SYNC_ALL) ? ST_SYNC : ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				if (rd_or_wr && !status.hit && status.evict_dirty)
					state_d = ST_WBACK;
				else if (status.mode == MODE_READ && !status.hit)
					state_d = ST_FILL;
				else
					state_d = ST_FINAL;
			end
			ST_WBACK: begin
				cmd.emit_sel = EM_VICTIM;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = (status.mode == MODE_READ) ? ST_FILL : ST_FINAL;
				end
			end
			ST_FILL: begin
				cmd.emit_sel = EM_FILL;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_FINAL;
				end
			end
			ST_FINAL: begin
				cmd.emit_sel = EM_FINAL;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SYNC: begin
				cmd.emit_sel = EM_SYNC;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.sync_last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- hw/rtl/lwbc_dp.sv -----
// Datapath of the block cache directory: tags, valid/dirty bits, LRU ranks,
// tag match, victim choice and the output register. Uses lwbc_pkg.
module lwbc_dp import lwbc_pkg::*; #(
	parameter int ENTRIES    = 16,
	parameter int BLOCK_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lwbc_cmd_t                 cmd,
	output lwbc_status_t              status,
	input  mode_t                     in_mode,
	input  logic [BLOCK_NUMBER_W-1:0] in_block_number,
	output logic                      out_valid,
	input  logic                      out_ready,
	output action_t                   out_action,
	output logic [SLOT_W-1:0]         out_slot,
	output logic [BLOCK_NUMBER_W-1:0] out_disk_block,
	output logic                      out_last
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int TAG_W = (BLOCK_BITS < BLOCK_NUMBER_W) ? BLOCK_BITS : BLOCK_NUMBER_W;

	logic [TAG_W-1:0]   tag_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q, valid_d, dirty_q, dirty_d;
	logic [IDX_W-1:0]   rank_q [ENTRIES];
	logic [IDX_W-1:0]   rank_d [ENTRIES];
	logic [CNT_W-1:0]   occ_q, occ_d;
	logic [ENTRIES-1:0] hit_vec_q, hit_vec_d, pend_q, pend_d;
	mode_t              mode_q;
	logic [TAG_W-1:0]   blk_q, vic_tag_q, rd_tag;
	logic [IDX_W-1:0]   slot_q;
	logic               so_wb_q;

	logic [IDX_W-1:0]   hit_idx, free_idx, lru_idx, pend_idx, sel, rd_idx;
	logic               hit, full, do_touch;
	logic [ENTRIES-1:0] pend_rest;

	logic                      out_valid_q, out_last_q;
	action_t                   out_act_q, em_act;
	logic [SLOT_W-1:0]         out_slot_q, em_slot;
	logic [BLOCK_NUMBER_W-1:0] out_blk_q, em_blk;
	logic                      em_last;

	// lowest-index encoders
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		lru_idx  = '0;
		pend_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (hit_vec_q[i])
				hit_idx = IDX_W'(i);
			if (!valid_q[i])
				free_idx = IDX_W'(i);
			if (valid_q[i] && rank_q[i] == '0)
				lru_idx = IDX_W'(i);
			if (pend_q[i])
				pend_idx = IDX_W'(i);
		end
	end

	assign hit       = |hit_vec_q;
	assign full      = (occ_q == CNT_W'(ENTRIES));
	assign sel       = hit ? hit_idx : (full ? lru_idx : free_idx);
	assign pend_rest = pend_q & ~(ENTRIES'(1) << pend_idx);
	assign rd_idx    = (cmd.emit_sel == EM_SYNC) ? pend_idx : lru_idx;
	assign rd_tag    = tag_q[rd_idx];

	always_comb begin
		for (int i = 0; i < ENTRIES; i++)
			hit_vec_d[i] = valid_q[i] && (tag_q[i] == blk_q);
	end

	// directory update
	always_comb begin
		valid_d  = valid_q;
		dirty_d  = dirty_q;
		rank_d   = rank_q;
		occ_d    = occ_q;
		pend_d   = pend_q;
		do_touch = 1'b0;
		if (cmd.lookup)
			pend_d = valid_q & dirty_q;
		if (cmd.decide) begin
			unique case (mode_q)
				MODE_READ, MODE_WRITE: begin
					if (hit) begin
						do_touch = 1'b1;
						if (mode_q == MODE_WRITE)
							dirty_d[hit_idx] = 1'b1;
					end else if (!full) begin
						valid_d[free_idx] = 1'b1;
						dirty_d[free_idx] = (mode_q == MODE_WRITE);
						rank_d[free_idx]  = IDX_W'(occ_q);
						occ_d             = occ_q + CNT_W'(1);
					end else begin
						do_touch         = 1'b1;
						dirty_d[lru_idx] = (mode_q == MODE_WRITE);
					end
				end
				MODE_SYNC_ONE: begin
					if (hit)
						dirty_d[hit_idx] = 1'b0;
				end
				MODE_SYNC_ALL: ;
			endcase
		end
		if (do_touch) begin
			for (int i = 0; i < ENTRIES; i++)
				if (valid_q[i] && IDX_W'(i) != sel && rank_q[i] > rank_q[sel])
					rank_d[i] = rank_q[i] - IDX_W'(1);
			rank_d[sel] = IDX_W'(occ_q - CNT_W'(1));
		end
		if (cmd.emit && cmd.emit_sel == EM_SYNC && (|pend_q)) begin
			dirty_d[pend_idx] = 1'b0;
			pend_d            = pend_rest;
		end
	end

	// result selection
	always_comb begin
		em_act  = ACT_NONE;
		em_slot = '0;
		em_blk  = '0;
		em_last = 1'b1;
		unique case (cmd.emit_sel)
			EM_VICTIM: begin
				em_act  = ACT_WBACK;
				em_slot = SLOT_W'(slot_q);
				em_blk  = BLOCK_NUMBER_W'(vic_tag_q);
				em_last = 1'b0;
			end
			EM_FILL: begin
				em_act  = ACT_FILL;
				em_slot = SLOT_W'(slot_q);
				em_blk  = BLOCK_NUMBER_W'(blk_q);
				em_last = 1'b0;
			end
			EM_FINAL: begin
				unique case (mode_q)
					MODE_READ:  em_act = ACT_SERVE;
					MODE_WRITE: em_act = ACT_TAKE;
					MODE_SYNC_ONE, MODE_SYNC_ALL: em_act = so_wb_q ? ACT_WBACK : ACT_NONE;
				endcase
				if (em_act != ACT_NONE) begin
					em_slot = SLOT_W'(slot_q);
					em_blk  = BLOCK_NUMBER_W'(blk_q);
				end
			end
			EM_SYNC: begin
				if (|pend_q) begin
					em_act  = ACT_WBACK;
					em_slot = SLOT_W'(pend_idx);
					em_blk  = BLOCK_NUMBER_W'(rd_tag);
					em_last = ~(|pend_rest);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			dirty_q     <= '0;
			occ_q       <= '0;
			pend_q      <= '0;
			hit_vec_q   <= '0;
			mode_q      <= MODE_READ;
			so_wb_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ENTRIES; i++)
				rank_q[i] <= '0;
		end else begin
			valid_q <= valid_d;
			dirty_q <= dirty_d;
			occ_q   <= occ_d;
			pend_q  <= pend_d;
			rank_q  <= rank_d;
			if (cmd.accept)
				mode_q <= in_mode;
			if (cmd.lookup)
				hit_vec_q <= hit_vec_d;
			if (cmd.decide)
				so_wb_q <= (mode_q == MODE_SYNC_ONE) && hit && dirty_q[hit_idx];
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			blk_q <= in_block_number[TAG_W-1:0];
		if (cmd.decide) begin
			slot_q    <= sel;
			vic_tag_q <= rd_tag;
			if ((mode_q == MODE_READ || mode_q == MODE_WRITE) && !hit)
				tag_q[sel] <= blk_q;
		end
		if (cmd.emit) begin
			out_act_q  <= em_act;
			out_slot_q <= em_slot;
			out_blk_q  <= em_blk;
			out_last_q <= em_last;
		end
	end

	assign status.mode        = mode_q;
	assign status.hit         = hit;
	assign status.evict_dirty = full && dirty_q[lru_idx];
	assign status.sync_last   = ~(|pend_rest);
	assign status.out_free    = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign out_action     = out_act_q;
	assign out_slot       = out_slot_q;
	assign out_disk_block = out_blk_q;
	assign out_last       = out_last_q;

endmodule

// ----- hw/rtl/lru_write_back_block_cache_directory_core.sv -----
// Fully associative write-back block cache directory with LRU replacement. One request
// (read, write, sync all, sync one) is taken at a time; it passes through input capture,
// tag match and, except for sync all, the decision that updates tags, dirty bits and LRU
// ranks. Each result then goes through the single output register, which loads a new
// result only while it is empty or being taken by the sink. A read or write hit gives one
// result, a write miss one or two, a read miss two or three (one more when a dirty victim
// is written back), a sync one a single result, and a sync all one per dirty slot (at
// least one). The next request is taken as soon as the last result of the previous one
// sits in the output register. There is no clearing pass: reset clears the valid, dirty
// and rank flops directly. Depends on lwbc_pkg, lwbc_ctrl and lwbc_dp.
module lru_write_back_block_cache_directory_core import lwbc_pkg::*; #(
	parameter int ENTRIES    = 16,
	parameter int BLOCK_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // mode[1:0], block_number[25:2]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // action[2:0], slot[6:3], disk_block[30:7]
	output logic                   m_axis_tlast
);

	lwbc_cmd_t                 cmd;
	lwbc_status_t              status;
	action_t                   action;
	logic [SLOT_W-1:0]         slot;
	logic [BLOCK_NUMBER_W-1:0] disk_block;

	lwbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lwbc_dp #(
		.ENTRIES    (ENTRIES),
		.BLOCK_BITS (BLOCK_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.in_mode         (mode_t'(s_axis_tdata[MODE_W-1:0])),
		.in_block_number (s_axis_tdata[MODE_W+BLOCK_NUMBER_W-1:MODE_W]),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_action      (action),
		.out_slot        (slot),
		.out_disk_block  (disk_block),
		.out_last        (m_axis_tlast)
	);

	assign m_axis_tdata = {
		{(OUT_TDATA_W - ACTION_W - SLOT_W - BLOCK_NUMBER_W){1'b0}},
		disk_block, slot, action
	};

endmodule
